FILE: design/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the radix digit converter: payload structs,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_BITS = 31;
   localparam int RADIX_BITS = 9;
   localparam int DIGIT_BITS = 8;
   localparam int COUNT_BITS = 5;
   localparam int RADIX_MAX  = 256;

   // digit counter holds 0..VALUE_BITS, digit store index 0..VALUE_BITS-1
   localparam int CNT_W = $clog2(VALUE_BITS + 1);
   localparam int IDX_W = $clog2(VALUE_BITS);
   localparam int BIT_W = $clog2(VALUE_BITS);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0] radix;
   } req_type;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic [COUNT_BITS-1:0] digit_count;
      logic                  last;
      logic                  bad_radix;
   } rsp_type;

   typedef struct packed {
      logic load;         // capture a new beat
      logic div_step;     // one restoring-division step
      logic store_digit;  // save remainder, restart division on quotient
      logic rd_issue;     // read digit store at current index
      logic rd_next;      // step index toward the least significant digit
      logic out_digit;    // load output register with a digit
      logic out_special;  // load output register with zero / error result
   } cmd_type;

   typedef struct packed {
      logic bad;          // radix outside 2..RADIX_MAX
      logic zero;         // working value is zero
      logic div_last;     // current division step is the final one
      logic rd_last;      // read index is at the least significant digit
      logic out_free;     // output register can take a beat this cycle
   } status_type;

endpackage

FILE: design/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer for the converter: division loop per digit, then readout of the
// stored digits most significant first.
// ----------------------------------------------------------------------------
module rdc_ctrl import rdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_CHECK   = 7'b0000010,
      S_DIV     = 7'b0000100,
      S_DONE    = 7'b0001000,
      S_READ    = 7'b0010000,
      S_SEND    = 7'b0100000,
      S_SPECIAL = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.bad || status.zero) begin
               state_in = S_SPECIAL;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.store_digit = 1'b1;
            // quotient zero means this was the most significant digit
            if (status.zero) begin
               state_in = S_READ;
            end else begin
               state_in = S_DIV;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_SEND;
         end
         S_SEND: begin
            if (status.out_free) begin
               cmd.out_digit = 1'b1;
               if (status.rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_SPECIAL: begin
            if (status.out_free) begin
               cmd.out_special = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/rdc_dpath.sv
// ----------------------------------------------------------------------------
// rdc_dpath
// Datapath: bit-serial restoring divider by the radix, digit store, and the
// output register.
// ----------------------------------------------------------------------------
module rdc_dpath import rdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [RADIX_BITS-1:0] radix_ff;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic [DIGIT_BITS-1:0] mem [VALUE_BITS];
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [RADIX_BITS:0]   trial;
   logic                  fits;

   // restoring step: shift in next dividend bit, subtract radix if it fits
   assign trial = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign fits  = (trial >= {1'b0, radix_ff});

   always_comb begin
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      if (cmd.load) begin
         dvd_in   = req_data.value;
         rem_in   = '0;
         bit_in   = '0;
         count_in = '0;
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[VALUE_BITS-2:0], fits};
         rem_in = fits ? RADIX_BITS'(trial - {1'b0, radix_ff}) : trial[RADIX_BITS-1:0];
         bit_in = bit_ff + 1'b1;
      end else if (cmd.store_digit) begin
         rem_in    = '0;
         bit_in    = '0;
         count_in  = count_ff + 1'b1;
         rd_idx_in = count_ff[IDX_W-1:0];
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (cmd.out_digit) begin
         rsp_in.digit       = rd_data_ff;
         rsp_in.digit_count = COUNT_BITS'(count_ff);
         rsp_in.last        = (rd_idx_ff == '0);
         rsp_in.bad_radix   = 1'b0;
         rsp_valid_in       = 1'b1;
      end else if (cmd.out_special) begin
         rsp_in.digit       = '0;
         rsp_in.digit_count = '0;
         rsp_in.last        = 1'b1;
         rsp_in.bad_radix   = status.bad;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      bit_ff    <= bit_in;
      count_ff  <= count_in;
      rd_idx_ff <= rd_idx_in;
      rsp_ff    <= rsp_in;
      if (cmd.load) begin
         radix_ff <= req_data.radix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // digit store: least significant digit at index zero
   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         mem[count_ff[IDX_W-1:0]] <= rem_ff[DIGIT_BITS-1:0];
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   always_comb begin
      status.bad      = (32'(radix_ff) < 32'd2) || (32'(radix_ff) > 32'(RADIX_MAX));
      status.zero     = (dvd_ff == '0);
      status.div_last = (bit_ff == BIT_W'(VALUE_BITS - 1));
      status.rd_last  = (rd_idx_ff == '0);
      status.out_free = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: design/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_top
// Converts a non-negative integer into its digits in a given radix and sends
// them out most significant first, one result beat per digit.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat carries value and radix (valid/ready). A beat is taken
//            only while the converter is idle.
//   rsp_*  : one beat per digit, each with the total digit count; the final
//            beat of an input has last set. A zero value gives one beat with
//            count 0. A radix below 2 or above 256 gives one beat with
//            bad_radix set and no digits.
// Operation:
//   Each digit costs one pass of the bit-serial divider, then a step to
//   store it. Readout then reads each digit from the registered digit store
//   before sending it. A value has at most 31 digits, in radix 2. Zero
//   values and bad radixes skip the divider.
// Reset:
//   Synchronous, active high. Clears the sequencer and the output valid.
// Stall:
//   Results sit in an output register; when rsp_ready is low the sequencer
//   holds with the next digit read and waiting. After the final beat is
//   loaded, a new request is accepted while that beat still waits.
// ----------------------------------------------------------------------------
module radix_digit_converter_top import rdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: divide per digit, then read back digits in reverse order
   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // divider, digit store and output register
   rdc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
